FILE: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared widths, op and state codes, and the records that move along the
// row of task cells.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int TASKS_DEF  = 16;
	localparam int SLOT_W     = 4;
	localparam int ARR_W      = 16;
	localparam int BURST_W    = 16;
	localparam int PRIO_W     = 8;
	localparam int TIME_W     = 24;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 5;
	localparam int NACT_W     = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 176;
	localparam int OUT_USER_W = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [NACT_W-1:0] NACT_MAX = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} pps_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_SUM
	} pps_state_t;

	typedef struct packed {
		logic               load;
		logic               clear;
		logic [SLOT_W-1:0]  slot;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} pps_cmd_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic [PRIO_W-1:0]  prio;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] remain;
		logic [NACT_W-1:0]  nact;
		logic               any_loaded;
	} pps_cand_t;

endpackage

FILE: sv/pps_cell.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler task cell
// Holds one task slot and passes the best ready candidate to its neighbor.
// ----------------------------------------------------------------------------
module pps_cell #(
	parameter int TASKS = pps_pkg::TASKS_DEF,
	parameter int IDX   = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pps_pkg::pps_cmd_t             cmd,
	input  logic                          dec_en,
	input  logic [$clog2(TASKS)-1:0]      dec_idx,
	input  logic [pps_pkg::TIME_W-1:0]    time_now,
	input  pps_pkg::pps_cand_t            cand_in,
	input  logic [$clog2(TASKS)-1:0]      idx_in,
	output pps_pkg::pps_cand_t            cand_out,
	output logic [$clog2(TASKS)-1:0]      idx_out
);

	localparam int IDX_W = $clog2(TASKS);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                          loaded_q;
	logic [pps_pkg::BURST_W-1:0]   rem_q;
	logic [pps_pkg::ARR_W-1:0]     arr_q;
	logic [pps_pkg::BURST_W-1:0]   burst_q;
	logic [pps_pkg::PRIO_W-1:0]    prio_q;
	pps_pkg::pps_cand_t            cand_q;
	logic [IDX_W-1:0]              idx_q;

	logic active;
	logic ready;
	logic take;
	logic hit;
	logic [pps_pkg::NACT_W-1:0] nact_next;

	assign hit    = cmd.load && (int'(cmd.slot) == IDX);
	assign active = loaded_q && (rem_q != '0);
	assign ready  = active && ({{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, arr_q} <= time_now);
	assign take   = ready && (!cand_in.found || (prio_q < cand_in.prio));

	always_comb begin
		nact_next = cand_in.nact;
		if (active && (cand_in.nact != pps_pkg::NACT_MAX)) begin
			nact_next = cand_in.nact + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			rem_q    <= '0;
		end else if (cmd.clear) begin
			loaded_q <= 1'b0;
			rem_q    <= '0;
		end else if (hit) begin
			loaded_q <= (cmd.burst != '0);
			rem_q    <= cmd.burst;
		end else if (dec_en && (dec_idx == MY_IDX)) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			arr_q   <= cmd.arrival;
			burst_q <= cmd.burst;
			prio_q  <= cmd.prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			idx_q  <= '0;
		end else begin
			cand_q.valid      <= cand_in.valid;
			cand_q.found      <= cand_in.found || take;
			cand_q.prio       <= take ? prio_q  : cand_in.prio;
			cand_q.arrival    <= take ? arr_q   : cand_in.arrival;
			cand_q.burst      <= take ? burst_q : cand_in.burst;
			cand_q.remain     <= take ? rem_q   : cand_in.remain;
			cand_q.nact       <= nact_next;
			cand_q.any_loaded <= cand_in.any_loaded || loaded_q;
			idx_q             <= take ? MY_IDX : idx_in;
		end
	end

	assign cand_out = cand_q;
	assign idx_out  = idx_q;

endmodule

FILE: sv/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table held in a row of cells; a tick runs the ready task with the
// smallest priority value and reports its completion figures.
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// s_*      in   slot, arrival, burst, prio          op
// m_*      out  ran_slot .. now_time (176 bits)     idle, finished
//
// A load, clear or unused op leaves the input ready; a tick holds it off until its result is registered.
// A tick walks the cell row one cell a cycle, then registers the pick,
//   forms the waiting time and updates the totals.
// The result sits in an output register while the next item is taken; a
//   tick stalls in its last step while that register holds an untaken item.
// Reset clears the table, time, count and totals.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int TASKS = pps_pkg::TASKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// slot[3:0], arrival[19:4], burst[35:20], prio[43:36], zero pad
	input  logic [pps_pkg::IN_DATA_W-1:0]    s_tdata,
	// op[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// ran_slot[3:0], completion_time[27:4], turnaround[51:28],
	// waiting[75:52], total_turnaround[107:76], total_waiting[139:108],
	// done_count[144:140], all_done[145], now_time[169:146], zero pad
	output logic [pps_pkg::OUT_DATA_W-1:0]   m_tdata,
	// idle[0], finished[1]
	output logic [pps_pkg::OUT_USER_W-1:0]   m_tuser
);

	localparam int IDX_W = $clog2(TASKS);
	localparam int TW    = pps_pkg::TIME_W;
	localparam int SW    = pps_pkg::SUM_W;

	pps_pkg::pps_state_t state_q, state_next;

	logic in_fire;
	logic tick_fire;
	logic scan_end;
	logic sum_go;

	pps_pkg::pps_cmd_t  cmd;
	pps_pkg::pps_cand_t cand [TASKS+1];
	logic [IDX_W-1:0]   idx  [TASKS+1];
	logic [TASKS-1:0]   tok_vec;

	logic [TW-1:0]            time_q;
	logic [pps_pkg::CNT_W-1:0] count_q;
	logic [SW-1:0]            sum_tat_q;
	logic [SW-1:0]            sum_wt_q;

	logic [TW-1:0] time_next;
	logic          fin;
	logic          any_left;

	logic                        found_s1;
	logic                        fin_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [TW-1:0]               tat_s1;
	logic [pps_pkg::BURST_W-1:0] burst_s1;
	logic                        all_done_s1;
	logic [TW-1:0]               wt_s2;

	logic [SW:0]   tat_sum;
	logic [SW:0]   wt_sum;
	logic [SW-1:0] tat_tot;
	logic [SW-1:0] wt_tot;
	logic [pps_pkg::CNT_W-1:0] count_next;

	logic                            m_valid_q;
	logic [pps_pkg::OUT_DATA_W-1:0]  m_data_q;
	logic [pps_pkg::OUT_USER_W-1:0]  m_user_q;

	assign in_fire   = s_tvalid && s_tready;
	assign tick_fire = in_fire && (s_tuser == pps_pkg::OP_TICK);
	assign scan_end  = cand[TASKS].valid;

	always_comb begin
		cmd.load    = in_fire && (s_tuser == pps_pkg::OP_LOAD);
		cmd.clear   = in_fire && (s_tuser == pps_pkg::OP_CLEAR);
		cmd.slot    = s_tdata[3:0];
		cmd.arrival = s_tdata[19:4];
		cmd.burst   = s_tdata[35:20];
		cmd.prio    = s_tdata[43:36];
	end

	assign cand[0] = '{valid: tick_fire, default: '0};
	assign idx[0]  = '0;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		pps_cell #(
			.TASKS (TASKS),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.dec_en   (scan_end && cand[TASKS].found),
			.dec_idx  (idx[TASKS]),
			.time_now (time_q),
			.cand_in  (cand[i]),
			.idx_in   (idx[i]),
			.cand_out (cand[i+1]),
			.idx_out  (idx[i+1])
		);
		assign tok_vec[i] = cand[i+1].valid;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: if (tick_fire) state_next = pps_pkg::ST_SCAN;
			pps_pkg::ST_SCAN: if (scan_end) state_next = pps_pkg::ST_WAIT;
			pps_pkg::ST_WAIT: state_next = pps_pkg::ST_SUM;
			pps_pkg::ST_SUM:  if (sum_go) state_next = pps_pkg::ST_IDLE;
			default:          state_next = pps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		sum_go   = 1'b0;
		case (state_q)
			pps_pkg::ST_IDLE: s_tready = 1'b1;
			pps_pkg::ST_SUM:  sum_go   = !m_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				sum_go   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		time_next = (time_q != pps_pkg::TIME_MAX) ? time_q + 1'b1 : time_q;
		fin       = cand[TASKS].found && (cand[TASKS].remain == 16'd1);
		any_left  = fin ? (cand[TASKS].nact == pps_pkg::NACT_MAX)
		                : (cand[TASKS].nact != '0);
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			found_s1    <= cand[TASKS].found;
			fin_s1      <= fin;
			idx_s1      <= idx[TASKS];
			tat_s1      <= fin ? time_next - {{(TW-pps_pkg::ARR_W){1'b0}}, cand[TASKS].arrival}
			                   : '0;
			burst_s1    <= cand[TASKS].burst;
			all_done_s1 <= cand[TASKS].any_loaded && !any_left;
		end
		if (state_q == pps_pkg::ST_WAIT) begin
			if (tat_s1 >= {{(TW-pps_pkg::BURST_W){1'b0}}, burst_s1}) begin
				wt_s2 <= tat_s1 - {{(TW-pps_pkg::BURST_W){1'b0}}, burst_s1};
			end else begin
				wt_s2 <= '0;
			end
		end
	end

	always_comb begin
		tat_sum    = {1'b0, sum_tat_q} + {{(SW+1-TW){1'b0}}, tat_s1};
		wt_sum     = {1'b0, sum_wt_q} + {{(SW+1-TW){1'b0}}, wt_s2};
		tat_tot    = tat_sum[SW] ? {SW{1'b1}} : tat_sum[SW-1:0];
		wt_tot     = wt_sum[SW] ? {SW{1'b1}} : wt_sum[SW-1:0];
		count_next = (fin_s1 && (count_q != pps_pkg::CNT_MAX)) ? count_q + 1'b1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			count_q   <= '0;
			sum_tat_q <= '0;
			sum_wt_q  <= '0;
		end else if (cmd.clear) begin
			time_q    <= '0;
			count_q   <= '0;
			sum_tat_q <= '0;
			sum_wt_q  <= '0;
		end else begin
			if (scan_end) begin
				time_q <= time_next;
			end
			if (sum_go) begin
				count_q   <= count_next;
				sum_tat_q <= tat_tot;
				sum_wt_q  <= wt_tot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (sum_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_go) begin
			m_data_q <= {
				6'd0,
				time_q,
				all_done_s1,
				count_next,
				wt_tot,
				tat_tot,
				wt_s2,
				tat_s1,
				fin_s1 ? time_q : {TW{1'b0}},
				found_s1 ? pps_pkg::SLOT_W'(idx_s1) : {pps_pkg::SLOT_W{1'b0}}
			};
			m_user_q <= {fin_s1, !found_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	property p_one_token;
		@(posedge clk) disable iff (!arst_n)
		$countones(tok_vec) <= 1;
	endproperty
	a_one_token: assert property (p_one_token)
		else $error("more than one candidate in the cell row");

	property p_ready_empty_row;
		@(posedge clk) disable iff (!arst_n)
		s_tready |-> (tok_vec == '0);
	endproperty
	a_ready_empty_row: assert property (p_ready_empty_row)
		else $error("input ready while a scan is in the cell row");

	property p_scan_end_state;
		@(posedge clk) disable iff (!arst_n)
		scan_end |-> (state_q == pps_pkg::ST_SCAN);
	endproperty
	a_scan_end_state: assert property (p_scan_end_state)
		else $error("candidate left the cell row outside a scan");

	property p_result_after_sum;
		@(posedge clk) disable iff (!arst_n)
		sum_go |=> m_tvalid && (state_q == pps_pkg::ST_IDLE);
	endproperty
	a_result_after_sum: assert property (p_result_after_sum)
		else $error("result not presented after the summing step");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load, tick, clear and unused-op items into the scheduler, keeps its own
// copy of the task table to predict every tick report, and compares each report
// with the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	import pps_pkg::*;

	localparam int NSLOT       = TASKS_DEF;
	localparam int RAND_ITEMS  = 1500;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN       = TASKS_DEF + 24;
	localparam int N_DIR       = 23;

	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] ran_slot;
		logic              idle;
		logic              finished;
		logic [TIME_W-1:0] done_at;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [SUM_W-1:0]  tat_total;
		logic [SUM_W-1:0]  wait_total;
		logic [CNT_W-1:0]  done_count;
		logic              all_done;
		logic [TIME_W-1:0] now_time;
	} tick_report_t;

	typedef struct {
		logic [1:0]         op;
		logic [SLOT_W-1:0]  slot;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		bit                 typed;
		tick_report_t       want;
	} stim_row_t;

	localparam tick_report_t FIRST_IDLE = '{idle: 1'b1, now_time: 24'd1, default: '0};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [OUT_USER_W-1:0]  m_tuser;

	logic [ARR_W-1:0]   task_arr   [NSLOT];
	logic [BURST_W-1:0] task_burst [NSLOT];
	logic [BURST_W-1:0] task_left  [NSLOT];
	logic [PRIO_W-1:0]  task_prio  [NSLOT];
	logic [NSLOT-1:0]   task_live;
	logic [TIME_W-1:0]  clock_now;
	logic [CNT_W-1:0]   tasks_done;
	logic [SUM_W-1:0]   tat_sum;
	logic [SUM_W-1:0]   wait_sum;

	tick_report_t pending_reports [$];
	int           errors = 0;
	int           cycle_count = 0;

	stim_row_t dir_rows [N_DIR] = '{
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b1, FIRST_IDLE},
		'{OP_NONE,  4'd9,  16'd5,     16'd5,     8'd5,   1'b0, '0},
		'{OP_LOAD,  4'd0,  16'd0,     16'd1,     8'd255, 1'b0, '0},
		'{OP_LOAD,  4'd15, 16'd0,     16'd2,     8'd0,   1'b0, '0},
		'{OP_LOAD,  4'd3,  16'd2,     16'd3,     8'd0,   1'b0, '0},
		'{OP_LOAD,  4'd5,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_LOAD,  4'd7,  16'hFFFF,  16'hFFFF,  8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_LOAD,  4'd7,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_LOAD,  4'd15, 16'hFFFF,  16'hFFFF,  8'hFF,  1'b0, '0},
		'{OP_CLEAR, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b1, FIRST_IDLE},
		'{OP_LOAD,  4'd15, 16'd0,     16'd1,     8'd255, 1'b0, '0},
		'{OP_TICK,  4'd0,  16'd0,     16'd0,     8'd0,   1'b0, '0}
	};

	preemptive_priority_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic table_clear();
		for (int i = 0; i < NSLOT; i++) begin
			task_arr[i]   = '0;
			task_burst[i] = '0;
			task_left[i]  = '0;
			task_prio[i]  = '0;
		end
		task_live  = '0;
		clock_now  = '0;
		tasks_done = '0;
		tat_sum    = '0;
		wait_sum   = '0;
	endtask

	task automatic schedule_step(
		input  logic [1:0]         op,
		input  logic [SLOT_W-1:0]  slot,
		input  logic [ARR_W-1:0]   arrival,
		input  logic [BURST_W-1:0] burst,
		input  logic [PRIO_W-1:0]  prio,
		output bit                 produced,
		output tick_report_t       rep
	);
		bit                found;
		bit                pending;
		int                pick;
		logic [PRIO_W-1:0] best;
		logic [TIME_W-1:0] tat;
		logic [TIME_W-1:0] wt;
		logic [SUM_W:0]    sum;

		rep      = '0;
		produced = 1'b0;
		case (op)
			OP_LOAD: begin
				task_arr[slot]   = arrival;
				task_burst[slot] = burst;
				task_prio[slot]  = prio;
				task_left[slot]  = burst;
				task_live[slot]  = (burst != '0);
			end
			OP_CLEAR: begin
				table_clear();
			end
			OP_TICK: begin
				found = 1'b0;
				pick  = 0;
				best  = '0;
				for (int i = 0; i < NSLOT; i++) begin
					if (task_live[i] && task_left[i] != '0 &&
							{8'd0, task_arr[i]} <= clock_now &&
							(!found || task_prio[i] < best)) begin
						found = 1'b1;
						pick  = i;
						best  = task_prio[i];
					end
				end
				if (clock_now != TIME_MAX)
					clock_now = clock_now + 1'b1;
				rep.idle     = !found;
				rep.ran_slot = found ? pick[SLOT_W-1:0] : '0;
				if (found) begin
					task_left[pick] = task_left[pick] - 1'b1;
					if (task_left[pick] == '0) begin
						tat = clock_now - {8'd0, task_arr[pick]};
						wt  = (tat >= {8'd0, task_burst[pick]}) ?
							tat - {8'd0, task_burst[pick]} : '0;
						sum      = {1'b0, tat_sum} + {9'd0, tat};
						tat_sum  = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
						sum      = {1'b0, wait_sum} + {9'd0, wt};
						wait_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
						if (tasks_done != CNT_MAX)
							tasks_done = tasks_done + 1'b1;
						rep.finished   = 1'b1;
						rep.done_at    = clock_now;
						rep.turnaround = tat;
						rep.waiting    = wt;
					end
				end
				pending = 1'b0;
				for (int i = 0; i < NSLOT; i++)
					if (task_live[i] && task_left[i] != '0)
						pending = 1'b1;
				rep.tat_total  = tat_sum;
				rep.wait_total = wait_sum;
				rep.done_count = tasks_done;
				rep.all_done   = (task_live != '0) && !pending;
				rep.now_time   = clock_now;
				produced       = 1'b1;
			end
			default: ;
		endcase
	endtask

	bit send_quiet;

	task automatic drive_item(
		input logic [1:0]         op,
		input logic [SLOT_W-1:0]  slot,
		input logic [ARR_W-1:0]   arrival,
		input logic [BURST_W-1:0] burst,
		input logic [PRIO_W-1:0]  prio,
		input bit                 typed,
		input tick_report_t       want
	);
		int           gap;
		bit           produced;
		tick_report_t rep;

		if ($urandom_range(0, 31) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, prio, burst, arrival, slot};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		schedule_step(op, slot, arrival, burst, prio, produced, rep);
		if (produced)
			pending_reports.push_back(typed ? want : rep);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		bit           recv_quiet;
		int           stall;
		tick_report_t want;

		m_tready   = 1'b0;
		recv_quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				recv_quiet = !recv_quiet;
			stall = recv_quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none pending, tdata %0h tuser %0h",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("ran_slot",         SUM_W'(want.ran_slot),
					SUM_W'(m_tdata[3:0]));
				check_field("idle",             SUM_W'(want.idle),
					SUM_W'(m_tuser[0]));
				check_field("finished",         SUM_W'(want.finished),
					SUM_W'(m_tuser[1]));
				check_field("completion_time",  SUM_W'(want.done_at),
					SUM_W'(m_tdata[27:4]));
				check_field("turnaround",       SUM_W'(want.turnaround),
					SUM_W'(m_tdata[51:28]));
				check_field("waiting",          SUM_W'(want.waiting),
					SUM_W'(m_tdata[75:52]));
				check_field("total_turnaround", want.tat_total,  m_tdata[107:76]);
				check_field("total_waiting",    want.wait_total, m_tdata[139:108]);
				check_field("done_count",       SUM_W'(want.done_count),
					SUM_W'(m_tdata[144:140]));
				check_field("all_done",         SUM_W'(want.all_done),
					SUM_W'(m_tdata[145]));
				check_field("now_time",         SUM_W'(want.now_time),
					SUM_W'(m_tdata[169:146]));
			end
			@(negedge clk);
		end
	end

	initial begin
		int                 sent;
		int                 phase;
		int                 phase_len;
		int                 pick;
		logic [TIME_W-1:0]  lo;
		logic [SLOT_W-1:0]  slot;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_LOAD;
		send_quiet  = 1'b0;
		table_clear();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_DIR; r++)
			drive_item(dir_rows[r].op, dir_rows[r].slot, dir_rows[r].arrival,
				dir_rows[r].burst, dir_rows[r].prio, dir_rows[r].typed, dir_rows[r].want);

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			if (phase == 1 || $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending_reports.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 2) == 0) begin
				drive_item(OP_CLEAR, '0, '0, '0, '0, 1'b0, '0);
				sent++;
			end
			phase_len = $urandom_range(10, 120);
			for (int k = 0; k < phase_len; k++) begin
				pick    = $urandom_range(0, 99);
				slot    = SLOT_W'($urandom_range(0, NSLOT - 1));
				arrival = ARR_W'($urandom_range(0, 65535));
				burst   = BURST_W'($urandom_range(0, 65535));
				prio    = PRIO_W'($urandom_range(0, 255));
				if (pick < 2) begin
					drive_item(OP_NONE, slot, arrival, burst, prio, 1'b0, '0);
				end else begin
					if (pick < 26) begin
						if (pick >= 5 && pick < 24) begin
							lo      = (clock_now > TIME_W'(3)) ? clock_now - TIME_W'(3) : '0;
							arrival = lo[ARR_W-1:0] + ARR_W'($urandom_range(0, 8));
							burst   = BURST_W'($urandom_range(1, 6));
							if ($urandom_range(0, 1) == 0)
								prio = PRIO_W'($urandom_range(0, 3));
						end else if (pick >= 24) begin
							burst = '0;
						end
						drive_item(OP_LOAD, slot, arrival, burst, prio, 1'b0, '0);
					end else begin
						drive_item(OP_TICK, slot, arrival, burst, prio, 1'b0, '0);
					end
					sent++;
				end
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
